// ===== design/srpg_pkg.sv =====
// shared types and constants for the stepper ramp pulse generator
// no dependencies
package srpg_pkg;

	localparam int unsigned DIST_W  = 32;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned SPEED_W = 17;
	localparam int unsigned STEPS_W = 31;
	localparam int unsigned COIL_W  = 4;

	localparam logic [CFG_W-1:0]   DEF_ACCEL_STEPS = 32'd123456;
	localparam logic [CFG_W-1:0]   DEF_ACCEL_RATE  = 32'd1000;
	localparam logic [SPEED_W-1:0] START_RATE      = 17'd50;
	localparam logic [SPEED_W-1:0] SPEED_MAX       = 17'd131071;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	localparam logic REG_ACCEL_STEPS = 1'b0;
	localparam logic REG_ACCEL_RATE  = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_ACCEL  = 2'd1,
		MODE_CRUISE = 2'd2,
		MODE_DECEL  = 2'd3
	} ramp_mode_t;

	typedef struct packed {
		logic              command;
		logic              direction;
		logic [DIST_W-1:0] distance;
	} in_item_t;

	typedef struct packed {
		logic [STEPS_W-1:0] steps_done;
		logic [SPEED_W-1:0] speed;
		ramp_mode_t         ramp_phase;
		logic               busy_res;
		logic [COIL_W-1:0]  coils;
		logic               step_pulse;
	} result_t;

	typedef struct packed {
		logic fire;
		logic load;
	} stage_ctl_t;

endpackage

// ===== design/srpg_in_stage.sv =====
// input register stage: holds one accepted word until the core consumes it
// depends on srpg_pkg
module srpg_in_stage
	import srpg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     advance,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic valid_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/srpg_ramp_core.sv =====
// ramp state registers and next-state logic for one command or tick
// depends on srpg_pkg
module srpg_ramp_core
	import srpg_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  in_item_t         item_s1,
	input  logic [CFG_W-1:0] accel_steps,
	input  logic [CFG_W-1:0] accel_rate,
	output result_t          result
);

	localparam int unsigned ACC_W  = (FRAC_BITS > SPEED_W) ? FRAC_BITS : SPEED_W;
	localparam int unsigned SUM_W  = ACC_W + 1;
	localparam int unsigned SSUM_W = CFG_W + 1;
	localparam int unsigned CRY_W  = SSUM_W - FRAC_BITS;

	logic                 running_q;
	ramp_mode_t           mode_q;
	logic                 dir_q;
	logic [STEPS_W-1:0]   target_q;
	logic [STEPS_W-1:0]   count_q;
	logic [FRAC_BITS-1:0] step_acc_q;
	logic [FRAC_BITS-1:0] speed_acc_q;
	logic [SPEED_W-1:0]   rate_q;
	logic [1:0]           phase_q;
	logic [COIL_W-1:0]    coil_q;

	logic                 running_d;
	ramp_mode_t           mode_d;
	logic                 dir_d;
	logic [STEPS_W-1:0]   target_d;
	logic [STEPS_W-1:0]   count_d;
	logic [FRAC_BITS-1:0] step_acc_d;
	logic [FRAC_BITS-1:0] speed_acc_d;
	logic [SPEED_W-1:0]   rate_d;
	logic [1:0]           phase_d;
	logic [COIL_W-1:0]    coil_d;
	logic                 pulse_d;

	logic [CFG_W-1:0]   eff_steps;
	logic [CFG_W-1:0]   eff_rate;
	logic [SUM_W-1:0]   step_sum;
	logic [SSUM_W-1:0]  speed_sum;
	logic [CRY_W-1:0]   speed_cry;
	logic [SSUM_W-1:0]  rate_up;
	logic [CFG_W-1:0]   remain;

	always_comb begin
		if (accel_steps == '0 || accel_rate == '0) begin
			eff_steps = DEF_ACCEL_STEPS;
			eff_rate  = DEF_ACCEL_RATE;
		end else begin
			eff_steps = accel_steps;
			eff_rate  = accel_rate;
		end
	end

	always_comb begin
		running_d   = running_q;
		mode_d      = mode_q;
		dir_d       = dir_q;
		target_d    = target_q;
		count_d     = count_q;
		step_acc_d  = step_acc_q;
		speed_acc_d = speed_acc_q;
		rate_d      = rate_q;
		phase_d     = phase_q;
		coil_d      = coil_q;
		pulse_d     = 1'b0;
		step_sum    = SUM_W'(step_acc_q) + SUM_W'(rate_q);
		speed_sum   = '0;
		speed_cry   = '0;
		rate_up     = '0;
		remain      = '0;
		if (item_s1.command == CMD_START) begin
			if (item_s1.distance != '0 && !item_s1.distance[DIST_W-1]) begin
				dir_d       = item_s1.direction;
				running_d   = 1'b1;
				target_d    = item_s1.distance[STEPS_W-1:0];
				mode_d      = MODE_ACCEL;
				step_acc_d  = '0;
				speed_acc_d = '0;
				rate_d      = START_RATE;
				count_d     = '0;
			end
		end else if (running_q) begin
			step_acc_d = step_sum[FRAC_BITS-1:0];
			if (step_sum[SUM_W-1:FRAC_BITS] != '0) begin
				pulse_d = 1'b1;
				count_d = count_q + STEPS_W'(1);
				coil_d  = COIL_W'(1) << phase_q;
				phase_d = dir_q ? phase_q + 2'd1 : phase_q - 2'd1;
				remain  = CFG_W'(target_q) - CFG_W'(count_d);
				if (count_d == target_q) begin
					mode_d    = MODE_IDLE;
					running_d = 1'b0;
				end else if (remain <= eff_steps && count_d >= (target_q >> 1)) begin
					mode_d = MODE_DECEL;
				end else if (CFG_W'(count_d) >= eff_steps) begin
					mode_d = MODE_CRUISE;
				end
			end
			if (mode_d == MODE_ACCEL || mode_d == MODE_DECEL) begin
				speed_sum   = SSUM_W'(speed_acc_q) + SSUM_W'(eff_rate);
				speed_cry   = speed_sum[SSUM_W-1:FRAC_BITS];
				speed_acc_d = speed_sum[FRAC_BITS-1:0];
				rate_up     = SSUM_W'(rate_q) + SSUM_W'(speed_cry);
				if (mode_d == MODE_ACCEL) begin
					rate_d = (rate_up > SSUM_W'(SPEED_MAX)) ? SPEED_MAX
						: rate_up[SPEED_W-1:0];
				end else if (speed_cry != '0 && SSUM_W'(rate_q) > SSUM_W'(speed_cry)
					&& rate_q > START_RATE) begin
					rate_d = rate_q - SPEED_W'(speed_cry);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			mode_q      <= MODE_IDLE;
			dir_q       <= 1'b0;
			target_q    <= '0;
			count_q     <= '0;
			step_acc_q  <= '0;
			speed_acc_q <= '0;
			rate_q      <= START_RATE;
			phase_q     <= 2'd0;
			coil_q      <= '0;
		end else if (fire) begin
			running_q   <= running_d;
			mode_q      <= mode_d;
			dir_q       <= dir_d;
			target_q    <= target_d;
			count_q     <= count_d;
			step_acc_q  <= step_acc_d;
			speed_acc_q <= speed_acc_d;
			rate_q      <= rate_d;
			phase_q     <= phase_d;
			coil_q      <= coil_d;
		end
	end

	always_comb begin
		result.step_pulse = pulse_d;
		result.coils      = coil_d;
		result.busy_res   = running_d;
		result.ramp_phase = mode_d;
		result.speed      = rate_d;
		result.steps_done = count_d;
	end

endmodule

// ===== design/srpg_out_stage.sv =====
// result register: holds one word until the downstream side takes it
// depends on srpg_pkg
module srpg_out_stage
	import srpg_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    out_ready,
	output logic    out_valid,
	output logic    advance,
	output result_t result_s2
);

	logic valid_q;

	assign out_valid = valid_q;
	assign advance   = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			result_s2 <= result;
		end
	end

endmodule

// ===== design/stepper_ramp_pulse_generator.sv =====
// trapezoidal stepper ramp generator, top level
// an accepted word passes the input register, then the result register, before its result word is offered
// throughput: one command or tick per cycle while m_axis_tready does not stall the result register
// reset: arst_n clears all control state, mode idle, speed 50, registers 123456 and 1000
// depends on srpg_pkg, srpg_in_stage, srpg_ramp_core, srpg_out_stage
module stepper_ramp_pulse_generator
	import srpg_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [39:0]      s_axis_tdata,  // direction, distance[31:0], zero pad
	input  logic             s_axis_tuser,  // command
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [55:0]      m_axis_tdata   // step_pulse, coils, busy_res, ramp_phase, speed, steps_done
);

	logic [CFG_W-1:0] accel_steps_q;
	logic [CFG_W-1:0] accel_rate_q;
	in_item_t         in_item;
	in_item_t         item_s1;
	logic             valid_s1;
	logic             advance;
	stage_ctl_t       ctl;
	result_t          result;
	result_t          result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_steps_q <= DEF_ACCEL_STEPS;
			accel_rate_q  <= DEF_ACCEL_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_STEPS: accel_steps_q <= cfg_data;
				REG_ACCEL_RATE:  accel_rate_q  <= cfg_data;
				default:         accel_rate_q  <= accel_rate_q;
			endcase
		end
	end

	assign in_item.command   = s_axis_tuser;
	assign in_item.direction = s_axis_tdata[0];
	assign in_item.distance  = s_axis_tdata[DIST_W:1];

	assign ctl.fire = valid_s1 && advance;
	assign ctl.load = valid_s1;

	srpg_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	srpg_ramp_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (ctl.fire),
		.item_s1     (item_s1),
		.accel_steps (accel_steps_q),
		.accel_rate  (accel_rate_q),
		.result      (result)
	);

	srpg_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ctl.load),
		.result    (result),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.advance   (advance),
		.result_s2 (result_s2)
	);

	assign m_axis_tdata = {result_s2.steps_done, result_s2.speed, result_s2.ramp_phase,
		result_s2.busy_res, result_s2.coils, result_s2.step_pulse};

	a_busy_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result_s2.busy_res == (result_s2.ramp_phase != MODE_IDLE)))
		else $error("busy flag disagrees with ramp phase");

	a_pulse_coil: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result_s2.step_pulse) |-> $onehot(result_s2.coils))
		else $error("step without a single active coil");

	a_pulse_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && result_s2.step_pulse) |-> (result_s2.steps_done != '0))
		else $error("step with zero step count");

	a_speed_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (result_s2.speed != '0))
		else $error("speed fell to zero");

endmodule
